[rtl/amhq_pkg.sv]
package amhq_pkg;

    localparam int CAPACITY_DEF      = 64;
    localparam int PAYLOAD_WIDTH_DEF = 32;
    localparam int PRIO_W            = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BAD_HDL = 2'd3
    } t_status;

endpackage

[rtl/amhq_hfree.sv]
// Lowest free handle finder: scans the live bits one handle per cycle.
module amhq_hfree #(
    parameter int CAPACITY = amhq_pkg::CAPACITY_DEF,
    localparam int HW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CAPACITY-1:0] i_live,
    output logic                o_done,
    output logic                o_found,
    output logic [HW-1:0]       o_handle
);

    logic          r_busy;
    logic [HW:0]   r_idx;

    // Step through the handles until a free one or the end is reached.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && !o_done) begin
            r_idx <= r_idx + (HW+1)'(1);
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_comb begin
        o_found  = (r_idx < (HW+1)'(CAPACITY)) && !i_live[r_idx[HW-1:0]];
        o_done   = r_busy && (o_found || (r_idx >= (HW+1)'(CAPACITY)));
        o_handle = r_idx[HW-1:0];
    end

endmodule

[rtl/addressable_max_heap_queue_core.sv]
// Channel | Handshake         | Fields
// request | i_valid / o_ready | i_operation, i_payload, i_priority_req, i_handle_in
// result  | o_valid / i_ready | o_status, o_handle_out, o_payload_out, o_priority_out,
//         |                   | o_count, o_empty_res
// One item is worked at a time; o_ready stays low until its result has been taken.
// An insert scans the live bits one handle per cycle and then sifts up, each level taking
// an S_UP_RD and an S_UP_CMP step. Updates sift up through the same steps or down, as removals
// do, through S_DN_RD, S_DN_SEL and S_DN_CMP; errors go straight to the done step.
// Reset clears the live bits and the count; the heap memories are not cleared.
// A stalled result holds in the output registers.
module addressable_max_heap_queue_core #(
    parameter int CAPACITY      = amhq_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_WIDTH = amhq_pkg::PAYLOAD_WIDTH_DEF,
    localparam int HW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_operation,
    input  logic [PAYLOAD_WIDTH-1:0]            i_payload,
    input  logic signed [amhq_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic [HW-1:0]                       i_handle_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic [HW-1:0]                       o_handle_out,
    output logic [PAYLOAD_WIDTH-1:0]            o_payload_out,
    output logic signed [amhq_pkg::PRIO_W-1:0]  o_priority_out,
    output logic [CW-1:0]                       o_count,
    output logic                                o_empty_res
);

    localparam int PW = amhq_pkg::PRIO_W;
    // Heap entry layout: owner handle, payload, priority.
    localparam int EW = HW + PAYLOAD_WIDTH + PW;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_POS, S_LOAD, S_UP_RD, S_UP_CMP,
        S_DN_RD, S_DN_SEL, S_DN_CMP, S_WB, S_DONE
    } t_state;

    // Heap slots and handle map.
    logic [EW-1:0]            m_ent [CAPACITY];
    logic [HW-1:0]            m_pos [CAPACITY];

    t_state                   r_state;
    logic [CAPACITY-1:0]      r_live;
    logic [CW-1:0]            r_cnt;
    amhq_pkg::t_op            r_op;
    logic [HW-1:0]            r_i, r_c;
    logic [EW-1:0]            r_ie, r_ce;
    logic [EW-1:0]            r_rd_a, r_rd_b;
    logic [HW-1:0]            r_pos_q;
    logic [PW-1:0]            r_req_prio;
    logic [PAYLOAD_WIDTH-1:0] r_req_pay;

    logic                     hf_start, hf_done, hf_found;
    logic [HW-1:0]            hf_handle;

    logic                     in_fire;
    logic [HW-1:0]            ent_ra, ent_rb, last_slot, parent_slot;
    logic [HW:0]              lft, rgt;
    logic                     mem_we;
    logic [EW-1:0]            mem_wd;
    logic [PW-1:0]            cmp_a, cmp_b;
    logic                     cmp_gt;

    amhq_hfree #(.CAPACITY(CAPACITY)) u_hfree (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hf_start),
        .i_live   (r_live),
        .o_done   (hf_done),
        .o_found  (hf_found),
        .o_handle (hf_handle)
    );

    assign in_fire     = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE) && !o_valid;
    assign hf_start    = in_fire
                         && (amhq_pkg::t_op'(i_operation) == amhq_pkg::OP_INSERT)
                         && (r_cnt < CW'(CAPACITY));
    assign lft         = {r_i, 1'b1};
    assign rgt         = lft + (HW+1)'(1);
    assign last_slot   = HW'(r_cnt - CW'(1));
    assign parent_slot = (r_i - HW'(1)) >> 1;

    // Shared signed comparator, its operands picked by the state.
    assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

    always_comb begin
        cmp_a = r_ie[PW-1:0];
        cmp_b = r_rd_a[PW-1:0];
        unique case (r_state)
            S_LOAD: begin
                cmp_a = r_req_prio;
                cmp_b = r_rd_b[PW-1:0];
            end
            S_DN_SEL: begin
                cmp_a = r_rd_b[PW-1:0];
                cmp_b = r_rd_a[PW-1:0];
            end
            S_DN_CMP: begin
                cmp_a = r_ce[PW-1:0];
                cmp_b = r_ie[PW-1:0];
            end
            default: ;
        endcase
    end

    // Read addresses and the single slot write of each step.
    always_comb begin
        ent_ra = '0;
        ent_rb = last_slot;
        mem_we = 1'b0;
        mem_wd = r_ie;
        unique case (r_state)
            S_POS: begin
                ent_ra = r_pos_q;
                ent_rb = (r_pos_q - HW'(1)) >> 1;
            end
            S_UP_RD: ent_ra = parent_slot;
            S_UP_CMP: begin
                mem_we = cmp_gt;
                mem_wd = r_rd_a;
            end
            S_DN_RD: begin
                ent_ra = lft[HW-1:0];
                ent_rb = rgt[HW-1:0];
            end
            S_DN_CMP: begin
                mem_we = cmp_gt;
                mem_wd = r_ce;
            end
            S_WB: mem_we = 1'b1;
            default: ;
        endcase
    end

    // Memories: one slot write with its handle position, registered reads.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_ent[r_i]                <= mem_wd;
            m_pos[mem_wd[EW-1:EW-HW]] <= r_i;
        end
        r_rd_a  <= m_ent[ent_ra];
        r_rd_b  <= m_ent[ent_rb];
        r_pos_q <= m_pos[i_handle_in];
    end

    // Sequencer: state, live bits, count and registered results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE) o_valid <= 1'b1;
            else if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op           <= amhq_pkg::t_op'(i_operation);
                        r_req_prio     <= i_priority_req;
                        r_req_pay      <= i_payload;
                        o_status       <= amhq_pkg::ST_OK;
                        o_handle_out   <= '0;
                        o_payload_out  <= '0;
                        o_priority_out <= '0;
                        unique case (amhq_pkg::t_op'(i_operation))
                            amhq_pkg::OP_INSERT: begin
                                if (r_cnt >= CW'(CAPACITY)) begin
                                    o_status <= amhq_pkg::ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            amhq_pkg::OP_UPDATE: begin
                                if (({1'b0, i_handle_in} >= (HW+1)'(CAPACITY)) ||
                                    !r_live[i_handle_in]) begin
                                    o_status <= amhq_pkg::ST_BAD_HDL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_POS;
                                end
                            end
                            amhq_pkg::OP_REMOVE: begin
                                if (r_cnt == '0) begin
                                    o_status <= amhq_pkg::ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_LOAD;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hf_done) begin
                        if (!hf_found) begin
                            o_status <= amhq_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_live[hf_handle] <= 1'b1;
                            r_ie         <= {hf_handle, r_req_pay, r_req_prio};
                            r_i          <= r_cnt[HW-1:0];
                            r_cnt        <= r_cnt + CW'(1);
                            o_handle_out <= hf_handle;
                            r_state      <= S_UP_RD;
                        end
                    end
                end
                S_POS: begin
                    // The handle's slot is known; its entry and parent are read next.
                    r_i     <= r_pos_q;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (r_op == amhq_pkg::OP_REMOVE) begin
                        // Hand out the root and move the last entry to the top.
                        o_handle_out   <= r_rd_a[EW-1:EW-HW];
                        o_payload_out  <= r_rd_a[PW+PAYLOAD_WIDTH-1:PW];
                        o_priority_out <= r_rd_a[PW-1:0];
                        r_live[r_rd_a[EW-1:EW-HW]] <= 1'b0;
                        r_cnt   <= r_cnt - CW'(1);
                        r_ie    <= r_rd_b;
                        r_i     <= '0;
                        r_state <= (r_cnt == CW'(1)) ? S_DONE : S_DN_RD;
                    end else begin
                        // New priority; below the root and above its parent goes up.
                        r_ie <= {r_rd_a[EW-1:PW], r_req_prio};
                        if (r_i != '0 && cmp_gt) r_state <= S_UP_RD;
                        else r_state <= S_DN_RD;
                    end
                end
                S_UP_RD: begin
                    if (r_i == '0) begin
                        r_state <= S_WB;
                    end else begin
                        r_c     <= parent_slot;
                        r_state <= S_UP_CMP;
                    end
                end
                S_UP_CMP: begin
                    // The parent moves down only if the entry is strictly greater.
                    if (cmp_gt) begin
                        r_i     <= r_c;
                        r_state <= S_UP_RD;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_DN_RD: begin
                    if ({1'b0, lft} >= (HW+2)'(r_cnt)) r_state <= S_WB;
                    else r_state <= S_DN_SEL;
                end
                S_DN_SEL: begin
                    // The right child wins only when present and strictly greater.
                    if (({1'b0, rgt} < (HW+2)'(r_cnt)) && cmp_gt) begin
                        r_c  <= rgt[HW-1:0];
                        r_ce <= r_rd_b;
                    end else begin
                        r_c  <= lft[HW-1:0];
                        r_ce <= r_rd_a;
                    end
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (cmp_gt) begin
                        r_i     <= r_c;
                        r_state <= S_DN_RD;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    // The moving entry settles in its final slot.
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_count     <= r_cnt;
                    o_empty_res <= (r_cnt == '0);
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The entry count never exceeds the capacity.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CW'(CAPACITY))
        else $error("entry count above capacity");
    // A result is raised only out of the done step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done step");
    // No new item is taken while a result waits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> !o_ready)
        else $error("ready while result pending");
    // The live handles match the entry count at each result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $countones(r_live) == int'(r_cnt))
        else $error("live handles disagree with count");

endmodule
